/* rtl/core/abrf_pkg.sv */
// Shared types and constants for the alpha-blend rectangle fill core.
package abrf_pkg;

    // Coordinate width: holds FRAME_WIDTH / FRAME_HEIGHT up to 4096
    localparam int COORD_W = 13;
    // Widest pixel address (4096 x 4096 frame)
    localparam int ADDR_MAX_W = 24;
    localparam int CHAN_W = 8;
    localparam int PIXEL_W = 32;
    localparam int SUM_W = 16;
    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    // floor(x / 255) == (x * 32897) >> 23 for every 16-bit blend sum
    localparam logic [SUM_W:0] DIV255_MUL = 17'd32897;
    localparam int DIV255_SHIFT = 23;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_BLEND = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CLEAR,
        BK_BLEND,
        BK_DRAIN,
        BK_READ,
        BK_RDWAIT
    } back_state_t;

    // Classified command word handed from front to back
    typedef struct packed {
        logic [1:0]            mode;
        logic [CHAN_W-1:0]     x0;
        logic [COORD_W-1:0]    x1;
        logic [CHAN_W-1:0]     y0;
        logic [COORD_W-1:0]    y1;
        logic [ADDR_MAX_W-1:0] base;
        logic [PIXEL_W-1:0]    color;
        logic                  clip;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

/* rtl/core/abrf_front.sv */
// Front end: takes commands, clips rectangles to the frame, queues the result.
module abrf_front #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [7:0]          rect_left,
    input  logic [7:0]          rect_top,
    input  logic [8:0]          rect_width,
    input  logic [8:0]          rect_height,
    input  logic [7:0]          fill_red,
    input  logic [7:0]          fill_green,
    input  logic [7:0]          fill_blue,
    input  logic [7:0]          fill_alpha,
    input  logic                init_active,
    input  abrf_pkg::fifo_stat_t fifo_stat,
    output logic                push,
    output abrf_pkg::cmd_t      cmd
);

    localparam logic [abrf_pkg::COORD_W-1:0] FW_C = abrf_pkg::COORD_W'(FRAME_WIDTH);
    localparam logic [abrf_pkg::COORD_W-1:0] FH_C = abrf_pkg::COORD_W'(FRAME_HEIGHT);

    logic                           valid_reg;
    logic                           valid_next;
    abrf_pkg::cmd_t                 cmd_reg;
    abrf_pkg::cmd_t                 cmd_next;
    logic                           accept;
    logic [abrf_pkg::COORD_W-1:0]   col_end;
    logic [abrf_pkg::COORD_W-1:0]   row_end;
    logic                           rect_clip;
    logic                           read_clip;

    // Handshake: one staged word, pushed when the queue has room
    assign push   = valid_reg && !fifo_stat.full;
    assign busy   = init_active || (valid_reg && fifo_stat.full);
    assign accept = start && !busy;
    assign cmd    = cmd_reg;

    // Clip the rectangle against the frame
    always_comb
    begin
        col_end   = abrf_pkg::COORD_W'(rect_left) + abrf_pkg::COORD_W'(rect_width);
        row_end   = abrf_pkg::COORD_W'(rect_top) + abrf_pkg::COORD_W'(rect_height);
        rect_clip = (rect_width != 9'd0) && (rect_height != 9'd0) &&
                    ((col_end > FW_C) || (row_end > FH_C));
        read_clip = (abrf_pkg::COORD_W'(rect_left) >= FW_C) ||
                    (abrf_pkg::COORD_W'(rect_top) >= FH_C);

        cmd_next.mode  = mode;
        cmd_next.x0    = rect_left;
        cmd_next.y0    = rect_top;
        cmd_next.x1    = (col_end > FW_C) ? FW_C : col_end;
        cmd_next.y1    = (row_end > FH_C) ? FH_C : row_end;
        cmd_next.base  = abrf_pkg::ADDR_MAX_W'(rect_top) *
                         abrf_pkg::ADDR_MAX_W'(FRAME_WIDTH);
        cmd_next.color = {fill_alpha, fill_blue, fill_green, fill_red};
        case (abrf_pkg::mode_t'(mode))
            abrf_pkg::MODE_BLEND: cmd_next.clip = rect_clip;
            abrf_pkg::MODE_READ:  cmd_next.clip = read_clip;
            default:              cmd_next.clip = 1'b0;
        endcase

        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* rtl/core/abrf_cmd_fifo.sv */
// Two-entry command queue between front and back ends.
module abrf_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  abrf_pkg::cmd_t       wr_cmd,
    input  logic                 pop,
    output abrf_pkg::cmd_t       rd_cmd,
    output abrf_pkg::fifo_stat_t stat
);

    abrf_pkg::cmd_t                entry_reg [abrf_pkg::QUEUE_DEPTH];
    logic [abrf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [abrf_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [abrf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [abrf_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [abrf_pkg::QPTR_W:0]     count_reg;
    logic [abrf_pkg::QPTR_W:0]     count_next;

    assign stat.full  = (count_reg == (abrf_pkg::QPTR_W + 1)'(abrf_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_cmd     = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("command queue underflow");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

/* rtl/core/abrf_back.sv */
// Back end: frame store, clear sweep, blend pipeline and pixel read.
module abrf_back #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abrf_pkg::fifo_stat_t fifo_stat,
    input  abrf_pkg::cmd_t       fifo_cmd,
    output logic                 pop,
    output logic                 init_active,
    output logic                 done,
    output logic [31:0]          pixel_value,
    output logic                 clipped
);

    localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW  = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int CW  = abrf_pkg::CHAN_W;
    localparam int PW  = abrf_pkg::PIXEL_W;
    localparam int NCH = PW / CW;

    abrf_pkg::back_state_t          state_reg;
    abrf_pkg::back_state_t          state_next;
    abrf_pkg::cmd_t                 cmd_reg;
    abrf_pkg::cmd_t                 cmd_next;
    logic [abrf_pkg::COORD_W-1:0]   x_reg;
    logic [abrf_pkg::COORD_W-1:0]   x_next;
    logic [abrf_pkg::COORD_W-1:0]   y_reg;
    logic [abrf_pkg::COORD_W-1:0]   y_next;
    logic [AW-1:0]                  base_reg;
    logic [AW-1:0]                  base_next;
    logic [AW-1:0]                  clr_addr_reg;
    logic [AW-1:0]                  clr_addr_next;
    logic                           done_reg;
    logic                           done_next;
    logic [PW-1:0]                  pixel_reg;
    logic [PW-1:0]                  pixel_next;
    logic                           clip_reg;
    logic                           clip_next;
    logic                           blend_issue;
    logic                           x_last;
    logic                           y_last;
    logic [AW-1:0]                  rd_addr;

    // Frame store and its ports
    logic [PW-1:0]                  frame_store_reg [PIX];
    logic [PW-1:0]                  rdata_reg;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [PW-1:0]                  wr_data;

    // Blend pipeline: read data -> weighted sums -> divide by 255 -> write
    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    logic [AW-1:0]                  a1_reg;
    logic [AW-1:0]                  a2_reg;
    logic [AW-1:0]                  a3_reg;
    logic [abrf_pkg::SUM_W-1:0]     sum_reg  [NCH];
    logic [abrf_pkg::SUM_W-1:0]     sum_next [NCH];
    logic [CW-1:0]                  quot_reg  [NCH];
    logic [CW-1:0]                  quot_next [NCH];
    logic [PW-1:0]                  quot_word;
    logic [CW-1:0]                  inv_alpha;
    logic [CW-1:0]                  alpha;
    logic [2*abrf_pkg::SUM_W-1:0]   prod [NCH];

    assign init_active = (state_reg == abrf_pkg::BK_INIT);
    assign done        = done_reg;
    assign pixel_value = pixel_reg;
    assign clipped     = clip_reg;

    assign x_last = ((x_reg + 1'b1) == cmd_reg.x1);
    assign y_last = ((y_reg + 1'b1) == cmd_reg.y1);

    // Sequencer: next state, counters and result
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        base_next     = base_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        pixel_next    = '0;
        clip_next     = 1'b0;
        pop           = 1'b0;
        blend_issue   = 1'b0;
        rd_addr       = base_reg + AW'(x_reg);

        case (state_reg)
            abrf_pkg::BK_INIT:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(PIX - 1))
                begin
                    state_next = abrf_pkg::BK_IDLE;
                end
            end
            abrf_pkg::BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop       = 1'b1;
                    cmd_next  = fifo_cmd;
                    x_next    = abrf_pkg::COORD_W'(fifo_cmd.x0);
                    y_next    = abrf_pkg::COORD_W'(fifo_cmd.y0);
                    base_next = fifo_cmd.base[AW-1:0];
                    case (abrf_pkg::mode_t'(fifo_cmd.mode))
                        abrf_pkg::MODE_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = abrf_pkg::BK_CLEAR;
                        end
                        abrf_pkg::MODE_BLEND:
                        begin
                            // nothing inside the frame: answer at once
                            if ((abrf_pkg::COORD_W'(fifo_cmd.x0) >= fifo_cmd.x1) ||
                                (abrf_pkg::COORD_W'(fifo_cmd.y0) >= fifo_cmd.y1))
                            begin
                                done_next = 1'b1;
                                clip_next = fifo_cmd.clip;
                            end
                            else
                            begin
                                state_next = abrf_pkg::BK_BLEND;
                            end
                        end
                        abrf_pkg::MODE_READ:
                        begin
                            if (fifo_cmd.clip)
                            begin
                                done_next = 1'b1;
                                clip_next = 1'b1;
                            end
                            else
                            begin
                                state_next = abrf_pkg::BK_READ;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            abrf_pkg::BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(PIX - 1))
                begin
                    done_next  = 1'b1;
                    state_next = abrf_pkg::BK_IDLE;
                end
            end
            abrf_pkg::BK_BLEND:
            begin
                // one pixel read issued per cycle, row by row
                blend_issue = 1'b1;
                if (x_last)
                begin
                    x_next    = abrf_pkg::COORD_W'(cmd_reg.x0);
                    y_next    = y_reg + 1'b1;
                    base_next = base_reg + AW'(FRAME_WIDTH);
                    if (y_last)
                    begin
                        state_next = abrf_pkg::BK_DRAIN;
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            abrf_pkg::BK_DRAIN:
            begin
                if (!(v1_reg || v2_reg || v3_reg))
                begin
                    done_next  = 1'b1;
                    clip_next  = cmd_reg.clip;
                    state_next = abrf_pkg::BK_IDLE;
                end
            end
            abrf_pkg::BK_READ:
            begin
                state_next = abrf_pkg::BK_RDWAIT;
            end
            abrf_pkg::BK_RDWAIT:
            begin
                done_next  = 1'b1;
                pixel_next = rdata_reg;
                state_next = abrf_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = abrf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= abrf_pkg::BK_INIT;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            v1_reg       <= blend_issue;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
        end
    end

    // Command, counters and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        base_reg  <= base_next;
        pixel_reg <= pixel_next;
        clip_reg  <= clip_next;
    end

    // Blend arithmetic per channel
    always_comb
    begin
        alpha     = cmd_reg.color[PW-1 -: CW];
        inv_alpha = abrf_pkg::CHAN_MAX - alpha;
        for (int i = 0; i < NCH; i++)
        begin
            sum_next[i] = abrf_pkg::SUM_W'(rdata_reg[i*CW +: CW]) *
                          abrf_pkg::SUM_W'(inv_alpha) +
                          abrf_pkg::SUM_W'(cmd_reg.color[i*CW +: CW]) *
                          abrf_pkg::SUM_W'(alpha);
            prod[i] = (2*abrf_pkg::SUM_W)'(sum_reg[i]) *
                      (2*abrf_pkg::SUM_W)'(abrf_pkg::DIV255_MUL);
            quot_next[i] = prod[i][abrf_pkg::DIV255_SHIFT +: CW];
            quot_word[i*CW +: CW] = quot_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= rd_addr;
        a2_reg <= a1_reg;
        a3_reg <= a2_reg;
        for (int i = 0; i < NCH; i++)
        begin
            sum_reg[i]  <= sum_next[i];
            quot_reg[i] <= quot_next[i];
        end
    end

    // Write port: clear sweeps or blended words
    always_comb
    begin
        wr_en   = v3_reg || (state_reg == abrf_pkg::BK_INIT) ||
                  (state_reg == abrf_pkg::BK_CLEAR);
        wr_addr = v3_reg ? a3_reg : clr_addr_reg;
        if (v3_reg)
        begin
            wr_data = quot_word;
        end
        else if (state_reg == abrf_pkg::BK_CLEAR)
        begin
            wr_data = cmd_reg.color;
        end
        else
        begin
            wr_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_store_reg[wr_addr] <= wr_data;
        end
        rdata_reg <= frame_store_reg[rd_addr];
    end

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == abrf_pkg::BK_IDLE) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("blend pipeline busy while idle");

    a_write_in_blend: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (state_reg == abrf_pkg::BK_BLEND || state_reg == abrf_pkg::BK_DRAIN))
        else $error("blend write outside a blend command");

    a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == abrf_pkg::BK_INIT) |=> !done_reg)
        else $error("result during clearing pass");

    a_pixel_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (pixel_reg != '0)) |-> !clip_reg)
        else $error("pixel returned with clipped set");

endmodule

/* rtl/core/alpha_blend_rect_fill_core.sv */
// A clear fills the whole frame with the fill colour, a read returns one stored pixel,
// a blend mixes each rectangle pixel inside the frame; empty or clipped-away commands
// answer without touching the frame store. The single frame store write port sets the
// throughput, one pixel per cycle. A two-word queue lets new commands in while the back
// end works; busy rises when it is full and a further command waits. After reset a
// clearing pass writes zero to all FRAME_WIDTH*FRAME_HEIGHT pixels, one per cycle,
// with busy high. done is a one-cycle strobe; the receiver cannot stall.
module alpha_blend_rect_fill_core #(
    parameter int FRAME_WIDTH  = 256,
    parameter int FRAME_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  rect_left,
    input  logic [7:0]  rect_top,
    input  logic [8:0]  rect_width,
    input  logic [8:0]  rect_height,
    input  logic [7:0]  fill_red,
    input  logic [7:0]  fill_green,
    input  logic [7:0]  fill_blue,
    input  logic [7:0]  fill_alpha,
    output logic        done,
    output logic [31:0] pixel_value,
    output logic        clipped
);

    logic                 push;
    logic                 pop;
    logic                 init_active;
    abrf_pkg::cmd_t       front_cmd;
    abrf_pkg::cmd_t       queue_cmd;
    abrf_pkg::fifo_stat_t fifo_stat;

    // Command intake and clipping
    abrf_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .fill_red    (fill_red),
        .fill_green  (fill_green),
        .fill_blue   (fill_blue),
        .fill_alpha  (fill_alpha),
        .init_active (init_active),
        .fifo_stat   (fifo_stat),
        .push        (push),
        .cmd         (front_cmd)
    );

    // Queue between front and back
    abrf_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .rd_cmd (queue_cmd),
        .stat   (fifo_stat)
    );

    // Frame store engine
    abrf_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_stat   (fifo_stat),
        .fifo_cmd    (queue_cmd),
        .pop         (pop),
        .init_active (init_active),
        .done        (done),
        .pixel_value (pixel_value),
        .clipped     (clipped)
    );

endmodule
